@@ rtl/cosa_pkg.sv @@
// Shared types, codes and constants of the cost-ordered slot allocator.
`timescale 1ns / 1ps
package cosa_pkg;

  localparam int COSA_SLOTS = 256;

  localparam logic [2:0] FUNC_LOAD    = 3'd0;
  localparam logic [2:0] FUNC_ALLOC   = 3'd1;
  localparam logic [2:0] FUNC_RELEASE = 3'd2;
  localparam logic [2:0] FUNC_DISABLE = 3'd3;
  localparam logic [2:0] FUNC_ENABLE  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR   = 3'd5;

  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_NO_ID   = 3'd1;
  localparam logic [2:0] RC_NO_FREE = 3'd2;
  localparam logic [2:0] RC_NOT_OCC = 3'd3;
  localparam logic [2:0] RC_FULL    = 3'd4;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [1:0] REG_ROW_LIMIT = 2'd0;
  localparam logic [1:0] REG_COL_LIMIT = 2'd1;
  localparam logic [1:0] REG_COL_STEP  = 2'd2;
  localparam logic [1:0] REG_ROW_STEP  = 2'd3;

  localparam logic [8:0] COUNT_MAX = 9'd511;

  typedef struct packed {
    logic [15:0]        id;
    logic [1:0]         st;
    logic signed [33:0] cost;
  } cosa_entry_t;

endpackage

@@ rtl/cosa_div.sv @@
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module cosa_div
  import cosa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [15:0] quot,
  output logic [8:0]  rem
);

  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [8:0]  dvs_r, dvs_nxt;
  logic [9:0]  trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[15]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 5'd0;
      quo_nxt = dividend;
      rem_nxt = 9'd0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 9'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

@@ rtl/cosa_mem.sv @@
// Slot table storage: one write port and one registered read port.
`timescale 1ns / 1ps
module cosa_mem
  import cosa_pkg::*;
#(
  parameter int SLOTS = COSA_SLOTS,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic [IDX_W-1:0]  rd_addr,
  output cosa_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  cosa_entry_t       wr_data
);

  cosa_entry_t mem [SLOTS];
  cosa_entry_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

@@ rtl/cost_ordered_slot_allocator.sv @@
// Top level of the cost-ordered slot allocator: sequencer, cost unit and counters.
`timescale 1ns / 1ps
// Usage. An item (in_func, in_packed_word, in_slot_ref) is taken at a rising edge
// with start high and busy low; busy then stays high until the result has gone.
// Exactly one result per item appears on the out_ ports for one cycle with
// out_valid high; the receiver cannot hold it off, so it must take it then.
// Registers are written on the cfg_ channel (cfg_ready is always high) by index:
// 0 row limit, 1 column limit, 2 column step cost, 3 row step cost. Write them
// only while busy is low.
// Sequence. Every item ends with a pass over the table that reads one entry per
// cycle, followed by the result cycle. Allocate, release, disable and enable first
// search the table, one entry per cycle; the last three only when the slot
// reference is nonzero and not above the entry count. A load of a valid entry into
// a table that is not full runs the divider (16 quotient bits), then the shared
// multiplier twice and the sum, then walks down the table moving one entry per
// cycle and inserts the new entry. The table memory has a single read port.
// Reset empties the table and zeroes the occupied count; the registers return to
// 0, 1, 256 and 256. Table contents are not cleared, only the fill count.
module cost_ordered_slot_allocator
  import cosa_pkg::*;
#(
  parameter int SLOTS = COSA_SLOTS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [17:0] in_packed_word,
  input  logic [15:0] in_slot_ref,
  output logic        out_valid,
  output logic [2:0]  out_result_code,
  output logic [15:0] out_slot_id,
  output logic [7:0]  out_slot_position,
  output logic [8:0]  out_occupied_count,
  output logic [8:0]  out_usable_count,
  output logic        out_free_valid,
  output logic [15:0] out_next_free_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_COST = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_SUMM = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [8:0]  row_r, col_r;
  logic [15:0] cstep_r, rstep_r;

  logic [3:0]         st_r, st_nxt;
  logic [2:0]         func_r, func_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [1:0]         lst_r, lst_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               pv_r, pv_nxt;
  logic [IDX_W-1:0]   pa_r, pa_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [8:0]         occ_r, occ_nxt;
  logic [8:0]         use_r, use_nxt;
  logic               fv_r, fv_nxt;
  logic [15:0]        nf_r, nf_nxt;
  logic [2:0]         code_r, code_nxt;
  logic [15:0]        sid_r, sid_nxt;
  logic [IDX_W-1:0]   spos_r, spos_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         r8_r, r8_nxt;
  logic               rneg_r, rneg_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic [31:0]        p1_r, p1_nxt;
  logic signed [33:0] cost_r, cost_nxt;
  logic               ov_r, ov_nxt;

  logic               div_start, div_done;
  logic [15:0]        div_quot;
  logic [8:0]         div_rem;
  logic [8:0]         cols;
  logic [15:0]        mul_a, mul_b;
  logic [17:0]        cap_rc;
  logic               full;
  logic               down, iss;
  logic [IDX_W-1:0]   rd_addr;
  cosa_entry_t        rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  cosa_entry_t        wr_data;
  logic               accept;

  assign busy      = (st_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cols      = (col_r == 9'd0) ? 9'd1 : col_r;
  assign cap_rc    = row_r * col_r;
  assign full      = (18'(cnt_r) >= cap_rc) || (cnt_r == CNT_W'(SLOTS));

  // The walk for a load runs from the top of the table downwards.
  assign down    = (st_r == S_WALK);
  assign iss     = down ? (idx_r != '0) : (idx_r < cnt_r);
  assign rd_addr = down ? IDX_W'(idx_r - CNT_W'(1)) : IDX_W'(idx_r);

  assign mul_a = (st_r == S_MUL1) ? div_quot : {8'd0, r8_r};
  assign mul_b = (st_r == S_MUL1) ? cstep_r : rstep_r;

  cosa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (id_r),
    .divisor  (cols),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  cosa_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 9'd0;
      col_r   <= 9'd1;
      cstep_r <= 16'd256;
      rstep_r <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_LIMIT: row_r   <= cfg_data[8:0];
        REG_COL_LIMIT: col_r   <= cfg_data[8:0];
        REG_COL_STEP:  cstep_r <= cfg_data;
        REG_ROW_STEP:  rstep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt    = st_r;
    func_nxt  = func_r;
    id_nxt    = id_r;
    lst_nxt   = lst_r;
    idx_nxt   = idx_r;
    pv_nxt    = 1'b0;
    pa_nxt    = pa_r;
    cnt_nxt   = cnt_r;
    occ_nxt   = occ_r;
    use_nxt   = use_r;
    fv_nxt    = fv_r;
    nf_nxt    = nf_r;
    code_nxt  = code_r;
    sid_nxt   = sid_r;
    spos_nxt  = spos_r;
    pos_nxt   = pos_r;
    r8_nxt    = r8_r;
    rneg_nxt  = rneg_r;
    prod_nxt  = prod_r;
    p1_nxt    = p1_r;
    cost_nxt  = cost_r;
    ov_nxt    = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pa_r;
    wr_data   = rd_data;

    // Pipelined table walks: issue one read a cycle, judge the one issued before.
    if (st_r == S_WALK || st_r == S_SCAN || st_r == S_SUMM) begin
      if (iss) begin
        pv_nxt  = 1'b1;
        pa_nxt  = rd_addr;
        idx_nxt = down ? CNT_W'(idx_r - CNT_W'(1)) : CNT_W'(idx_r + CNT_W'(1));
      end
    end

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          code_nxt = RC_OK;
          sid_nxt  = 16'd0;
          spos_nxt = '0;
          idx_nxt  = '0;
          use_nxt  = 9'd0;
          fv_nxt   = 1'b0;
          nf_nxt   = 16'd0;
          st_nxt   = S_SUMM;
          case (in_func)
            FUNC_LOAD: begin
              if (in_packed_word[17:16] == ST_INVALID) begin
                code_nxt = RC_NO_ID;
              end else if (full) begin
                code_nxt = RC_FULL;
              end else begin
                id_nxt  = in_packed_word[15:0];
                lst_nxt = in_packed_word[17:16];
                st_nxt  = S_DIV;
              end
            end
            FUNC_ALLOC: begin
              code_nxt = RC_NO_FREE;
              st_nxt   = S_SCAN;
            end
            FUNC_RELEASE, FUNC_DISABLE, FUNC_ENABLE: begin
              code_nxt = RC_NO_ID;
              id_nxt   = in_slot_ref;
              if (in_slot_ref != 16'd0 && in_slot_ref <= 16'(cnt_r)) begin
                st_nxt = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              cnt_nxt = '0;
              occ_nxt = 9'd0;
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        // Start the divider on entry to S_DIV, with the id already registered.
        div_start = !pv_r;
        pv_nxt    = 1'b1;
        if (div_done) begin
          pv_nxt = 1'b0;
          st_nxt = S_MUL1;
          // The row offset uses (id - 1) rem cols, derived from id rem cols.
          if (id_r == 16'd0) begin
            rneg_nxt = (cols != 9'd1);
            r8_nxt   = 8'd0;
          end else begin
            rneg_nxt = 1'b0;
            r8_nxt   = (div_rem == 9'd0) ? 8'(cols - 9'd1) : 8'(div_rem - 9'd1);
          end
        end
      end

      S_MUL1: begin
        prod_nxt = mul_a * mul_b;
        st_nxt   = S_MUL2;
      end

      S_MUL2: begin
        p1_nxt   = prod_r;
        prod_nxt = mul_a * mul_b;
        st_nxt   = S_COST;
      end

      S_COST: begin
        if (rneg_r) begin
          cost_nxt = $signed({2'b00, p1_r}) - $signed({18'd0, rstep_r});
        end else begin
          cost_nxt = $signed({2'b00, p1_r}) + $signed({2'b00, prod_r});
        end
        idx_nxt = cnt_r;
        st_nxt  = S_WALK;
      end

      S_WALK: begin
        if (pv_r) begin
          if (rd_data.cost > cost_r) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(pa_r + IDX_W'(1));
            wr_data = rd_data;
          end else begin
            pos_nxt = IDX_W'(pa_r + IDX_W'(1));
            st_nxt  = S_INS;
          end
        end else if (!iss) begin
          pos_nxt = '0;
          st_nxt  = S_INS;
        end
      end

      S_INS: begin
        wr_en        = 1'b1;
        wr_addr      = pos_r;
        wr_data.id   = id_r;
        wr_data.st   = lst_r;
        wr_data.cost = cost_r;
        cnt_nxt      = CNT_W'(cnt_r + CNT_W'(1));
        if (lst_r == ST_OCCUPIED && occ_r != COUNT_MAX) begin
          occ_nxt = occ_r + 9'd1;
        end
        sid_nxt  = id_r;
        spos_nxt = pos_r;
        idx_nxt  = '0;
        st_nxt   = S_SUMM;
      end

      S_SCAN: begin
        if (pv_r) begin
          if (func_r == FUNC_ALLOC) begin
            if (rd_data.st == ST_FREE) begin
              wr_en      = 1'b1;
              wr_data.st = ST_OCCUPIED;
              if (occ_r != COUNT_MAX) begin
                occ_nxt = occ_r + 9'd1;
              end
              code_nxt = RC_OK;
              sid_nxt  = rd_data.id;
              spos_nxt = pa_r;
              idx_nxt  = '0;
              pv_nxt   = 1'b0;
              st_nxt   = S_SUMM;
            end
          end else if (rd_data.id == id_r) begin
            idx_nxt = '0;
            pv_nxt  = 1'b0;
            st_nxt  = S_SUMM;
            if (func_r == FUNC_RELEASE && rd_data.st != ST_OCCUPIED) begin
              code_nxt = RC_NOT_OCC;
            end else begin
              wr_en    = 1'b1;
              code_nxt = RC_OK;
              sid_nxt  = rd_data.id;
              spos_nxt = pa_r;
              if (func_r == FUNC_RELEASE) begin
                wr_data.st = ST_FREE;
                if (occ_r != 9'd0) begin
                  occ_nxt = occ_r - 9'd1;
                end
              end else if (func_r == FUNC_DISABLE) begin
                wr_data.st = ST_DISABLED;
              end else begin
                wr_data.st = ST_FREE;
              end
            end
          end
        end else if (!iss) begin
          idx_nxt = '0;
          st_nxt  = S_SUMM;
        end
      end

      S_SUMM: begin
        if (pv_r) begin
          if (rd_data.st != ST_DISABLED && use_r != COUNT_MAX) begin
            use_nxt = use_r + 9'd1;
          end
          if (!fv_r && rd_data.st == ST_FREE) begin
            fv_nxt = 1'b1;
            nf_nxt = rd_data.id;
          end
        end else if (!iss) begin
          ov_nxt = 1'b1;
          st_nxt = S_OUT;
        end
      end

      S_OUT: begin
        st_nxt = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      occ_r  <= 9'd0;
      pv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      occ_r  <= occ_nxt;
      pv_r   <= pv_nxt;
      ov_r   <= ov_nxt;
    end
    func_r <= func_nxt;
    id_r   <= id_nxt;
    lst_r  <= lst_nxt;
    idx_r  <= idx_nxt;
    pa_r   <= pa_nxt;
    use_r  <= use_nxt;
    fv_r   <= fv_nxt;
    nf_r   <= nf_nxt;
    code_r <= code_nxt;
    sid_r  <= sid_nxt;
    spos_r <= spos_nxt;
    pos_r  <= pos_nxt;
    r8_r   <= r8_nxt;
    rneg_r <= rneg_nxt;
    prod_r <= prod_nxt;
    p1_r   <= p1_nxt;
    cost_r <= cost_nxt;
  end

  assign out_valid          = ov_r;
  assign out_result_code    = code_r;
  assign out_slot_id        = sid_r;
  assign out_slot_position  = 8'(spos_r);
  assign out_occupied_count = occ_r;
  assign out_usable_count   = use_r;
  assign out_free_valid     = fv_r;
  assign out_next_free_id   = nf_r;

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == S_OUT))
    else $error("result strobe outside the output cycle");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("fill count beyond table depth");

endmodule
